// ===== hdl/scedg_pkg.sv =====
// ----------------------------------------------------------------------------
// scedg_pkg
// shared types and constants of the sphere carve edge density block
// ----------------------------------------------------------------------------
package scedg_pkg;

  localparam int SQRT_STEPS = 51;
  localparam int DIV_STEPS  = 16;
  localparam int GEO_STAGES = 8;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_ISO      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] first_x;
    logic signed [23:0] first_y;
    logic signed [23:0] first_z;
    logic signed [23:0] second_x;
    logic signed [23:0] second_y;
    logic signed [23:0] second_z;
    logic signed [15:0] first_density;
    logic signed [15:0] second_density;
    logic               first_dug;
    logic               second_dug;
    logic [1:0]         edge_axis;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] new_first_density;
    logic signed [15:0] new_second_density;
    logic               new_first_dug;
    logic               new_second_dug;
    logic               edited;
  } out_beat_t;

  // per-edge control carried along the pipe
  typedef struct packed {
    logic signed [15:0] d1;
    logic signed [15:0] d2;
    logic               dug1;
    logic               dug2;
    logic [1:0]         axis;
    logic               zdiv;
    logic               in1;
    logic               act;
  } meta_t;

  typedef struct packed {
    meta_t              meta;
    logic [49:0]        a;
    logic signed [50:0] h;
    logic [101:0]       disc;
  } geo_t;

  typedef struct packed {
    meta_t              meta;
    logic [49:0]        a;
    logic signed [50:0] h;
    logic [50:0]        s;
  } sq_t;

  typedef struct packed {
    meta_t       meta;
    logic [16:0] mu;
  } fr_t;

endpackage

// ===== hdl/scedg_geom.sv =====
// ----------------------------------------------------------------------------
// scedg_geom
// edge vectors, inside tests, quadratic terms and discriminant
// ----------------------------------------------------------------------------
module scedg_geom (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  scedg_pkg::in_beat_t in_beat,
  input  logic signed [23:0]  cx,
  input  logic signed [23:0]  cy,
  input  logic signed [23:0]  cz,
  input  logic [19:0]         radius,
  output logic                out_vld,
  output scedg_pkg::geo_t     out_geo
);
  import scedg_pkg::*;

  logic [GEO_STAGES-1:0] vld_r;
  meta_t                 meta_r [1:GEO_STAGES];

  logic signed [24:0] p1 [3];
  logic signed [24:0] p2 [3];
  logic signed [24:0] pc [3];
  logic signed [24:0] d_c [3];
  logic signed [24:0] w_c [3];
  logic signed [24:0] e_c [3];
  logic               zdiv_c;
  meta_t              meta_c;

  logic signed [24:0] d_r [3];
  logic signed [24:0] w_r [3];
  logic signed [24:0] e_r [3];
  logic [39:0]        rr_r;

  logic signed [49:0] dd_r [3];
  logic signed [49:0] dw_r [3];
  logic signed [49:0] ww_r [3];
  logic signed [49:0] ee_r [3];

  logic signed [51:0] a3_r;
  logic signed [51:0] h3_r;
  logic signed [51:0] q13_r;
  logic signed [51:0] q23_r;

  logic               in1_c;
  logic               in2_c;
  logic signed [51:0] c_c;
  logic signed [51:0] habs_c;
  logic signed [51:0] cabs_c;
  meta_t              meta4_c;

  logic [49:0]        a_r [4:GEO_STAGES];
  logic signed [50:0] h_r [4:GEO_STAGES];
  logic [49:0]        habs4_r;
  logic [49:0]        cabs4_r;
  logic               cneg_r [4:7];

  logic [49:0] hhh5_r;
  logic [49:0] hhl5_r;
  logic [49:0] hll5_r;
  logic [49:0] ahh5_r;
  logic [49:0] ahl5_r;
  logic [49:0] alh5_r;
  logic [49:0] all5_r;

  logic [99:0] hcat6_r;
  logic [50:0] hmid6_r;
  logic [99:0] acat6_r;
  logic [50:0] amid6_r;

  logic [100:0] h27_r;
  logic [100:0] ac7_r;

  logic [101:0] diff_c;
  logic [101:0] disc_r;

  always_comb begin
    p1[0] = {in_beat.first_x[23], in_beat.first_x};
    p1[1] = {in_beat.first_y[23], in_beat.first_y};
    p1[2] = {in_beat.first_z[23], in_beat.first_z};
    p2[0] = {in_beat.second_x[23], in_beat.second_x};
    p2[1] = {in_beat.second_y[23], in_beat.second_y};
    p2[2] = {in_beat.second_z[23], in_beat.second_z};
    pc[0] = {cx[23], cx};
    pc[1] = {cy[23], cy};
    pc[2] = {cz[23], cz};
    for (int k = 0; k < 3; k++) begin
      d_c[k] = p2[k] - p1[k];
      w_c[k] = p1[k] - pc[k];
      e_c[k] = p2[k] - pc[k];
    end
    unique case (in_beat.edge_axis)
      AXIS_X:    zdiv_c = (d_c[0] == 25'sd0);
      AXIS_Y:    zdiv_c = (d_c[1] == 25'sd0);
      AXIS_Z:    zdiv_c = (d_c[2] == 25'sd0);
      AXIS_NONE: zdiv_c = 1'b0;
    endcase
    meta_c.d1   = in_beat.first_density;
    meta_c.d2   = in_beat.second_density;
    meta_c.dug1 = in_beat.first_dug;
    meta_c.dug2 = in_beat.second_dug;
    meta_c.axis = in_beat.edge_axis;
    meta_c.zdiv = zdiv_c;
    meta_c.in1  = 1'b0;
    meta_c.act  = 1'b0;
  end

  always_comb begin
    in1_c  = q13_r[50:0] < 51'(rr_r);
    in2_c  = q23_r[50:0] < 51'(rr_r);
    c_c    = q13_r - $signed({12'b0, rr_r});
    habs_c = h3_r[51] ? -h3_r : h3_r;
    cabs_c = c_c[51] ? -c_c : c_c;
    meta4_c      = meta_r[3];
    meta4_c.in1  = in1_c;
    meta4_c.act  = (in1_c != in2_c) && (meta_r[3].d1[15] || meta_r[3].d2[15])
                   && !(meta_r[3].dug1 && meta_r[3].dug2);
  end

  assign diff_c = 102'(h27_r) - 102'(ac7_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[GEO_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      for (int k = 0; k < 3; k++) begin
        d_r[k] <= d_c[k];
        w_r[k] <= w_c[k];
        e_r[k] <= e_c[k];
      end
      meta_r[1] <= meta_c;
      rr_r      <= {20'b0, radius} * {20'b0, radius};
      // stage 2
      for (int k = 0; k < 3; k++) begin
        dd_r[k] <= d_r[k] * d_r[k];
        dw_r[k] <= d_r[k] * w_r[k];
        ww_r[k] <= w_r[k] * w_r[k];
        ee_r[k] <= e_r[k] * e_r[k];
      end
      meta_r[2] <= meta_r[1];
      // stage 3
      a3_r      <= 52'(dd_r[0]) + 52'(dd_r[1]) + 52'(dd_r[2]);
      h3_r      <= 52'(dw_r[0]) + 52'(dw_r[1]) + 52'(dw_r[2]);
      q13_r     <= 52'(ww_r[0]) + 52'(ww_r[1]) + 52'(ww_r[2]);
      q23_r     <= 52'(ee_r[0]) + 52'(ee_r[1]) + 52'(ee_r[2]);
      meta_r[3] <= meta_r[2];
      // stage 4
      meta_r[4] <= meta4_c;
      a_r[4]    <= a3_r[49:0];
      h_r[4]    <= h3_r[50:0];
      habs4_r   <= habs_c[49:0];
      cabs4_r   <= cabs_c[49:0];
      cneg_r[4] <= c_c[51];
      // stage 5: partial products
      hhh5_r    <= habs4_r[49:25] * habs4_r[49:25];
      hhl5_r    <= habs4_r[49:25] * habs4_r[24:0];
      hll5_r    <= habs4_r[24:0] * habs4_r[24:0];
      ahh5_r    <= a_r[4][49:25] * cabs4_r[49:25];
      ahl5_r    <= a_r[4][49:25] * cabs4_r[24:0];
      alh5_r    <= a_r[4][24:0] * cabs4_r[49:25];
      all5_r    <= a_r[4][24:0] * cabs4_r[24:0];
      // stage 6
      hcat6_r   <= {hhh5_r, hll5_r};
      hmid6_r   <= {hhl5_r, 1'b0};
      acat6_r   <= {ahh5_r, all5_r};
      amid6_r   <= 51'(ahl5_r) + 51'(alh5_r);
      // stage 7
      h27_r     <= 101'(hcat6_r) + (101'(hmid6_r) << 25);
      ac7_r     <= 101'(acat6_r) + (101'(amid6_r) << 25);
      // stage 8
      if (cneg_r[7]) begin
        disc_r <= 102'(h27_r) + 102'(ac7_r);
      end else if (diff_c[101]) begin
        disc_r <= '0;
      end else begin
        disc_r <= diff_c;
      end
      for (int s = 5; s <= GEO_STAGES; s++) begin
        meta_r[s] <= meta_r[s-1];
        a_r[s]    <= a_r[s-1];
        h_r[s]    <= h_r[s-1];
      end
      for (int s = 5; s <= 7; s++) begin
        cneg_r[s] <= cneg_r[s-1];
      end
    end
  end

  assign out_vld      = vld_r[GEO_STAGES-1];
  assign out_geo.meta = meta_r[GEO_STAGES];
  assign out_geo.a    = a_r[GEO_STAGES];
  assign out_geo.h    = h_r[GEO_STAGES];
  assign out_geo.disc = disc_r;

endmodule

// ===== hdl/scedg_sqrt.sv =====
// ----------------------------------------------------------------------------
// scedg_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module scedg_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  scedg_pkg::geo_t in_geo,
  output logic            out_vld,
  output scedg_pkg::sq_t  out_sq
);
  import scedg_pkg::*;

  logic [SQRT_STEPS-1:0] vld_r;
  logic [53:0]           rem_r  [SQRT_STEPS];
  logic [50:0]           root_r [SQRT_STEPS];
  logic [101:0]          rad_r  [SQRT_STEPS];
  meta_t                 meta_r [SQRT_STEPS];
  logic [49:0]           a_r    [SQRT_STEPS];
  logic signed [50:0]    h_r    [SQRT_STEPS];

  logic [53:0]        src_rem  [SQRT_STEPS];
  logic [50:0]        src_root [SQRT_STEPS];
  logic [101:0]       src_rad  [SQRT_STEPS];
  meta_t              src_meta [SQRT_STEPS];
  logic [49:0]        src_a    [SQRT_STEPS];
  logic signed [50:0] src_h    [SQRT_STEPS];

  always_comb begin
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_rad[0]  = in_geo.disc;
    src_meta[0] = in_geo.meta;
    src_a[0]    = in_geo.a;
    src_h[0]    = in_geo.h;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      src_rem[k]  = rem_r[k-1];
      src_root[k] = root_r[k-1];
      src_rad[k]  = rad_r[k-1];
      src_meta[k] = meta_r[k-1];
      src_a[k]    = a_r[k-1];
      src_h[k]    = h_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [53:0] rem_n;
    logic [53:0] trial;
    logic        ge;

    always_comb begin
      rem_n = {src_rem[k][51:0], src_rad[k][101:100]};
      trial = {1'b0, src_root[k], 2'b01};
      ge    = rem_n >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rem_n - trial) : rem_n;
        root_r[k] <= {src_root[k][49:0], ge};
        rad_r[k]  <= {src_rad[k][99:0], 2'b00};
        meta_r[k] <= src_meta[k];
        a_r[k]    <= src_a[k];
        h_r[k]    <= src_h[k];
      end
    end
  end

  assign out_vld     = vld_r[SQRT_STEPS-1];
  assign out_sq.meta = meta_r[SQRT_STEPS-1];
  assign out_sq.a    = a_r[SQRT_STEPS-1];
  assign out_sq.h    = h_r[SQRT_STEPS-1];
  assign out_sq.s    = root_r[SQRT_STEPS-1];

endmodule

// ===== hdl/scedg_frac.sv =====
// ----------------------------------------------------------------------------
// scedg_frac
// crossing numerator, clamp and pipelined divide to a Q0.16 fraction
// ----------------------------------------------------------------------------
module scedg_frac (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  scedg_pkg::sq_t in_sq,
  output logic           out_vld,
  output scedg_pkg::fr_t out_fr
);
  import scedg_pkg::*;

  localparam int NST = DIV_STEPS + 3;

  logic [NST-1:0] vld_r;

  logic signed [52:0] num1_r;
  meta_t              meta1_r;
  logic [49:0]        a1_r;
  logic signed [52:0] nh_c;
  logic signed [52:0] sx_c;

  logic [49:0] rem_r  [DIV_STEPS+1];
  logic [15:0] q_r    [DIV_STEPS+1];
  logic [49:0] a_r    [DIV_STEPS+1];
  meta_t       meta_r [DIV_STEPS+1];
  logic        one_r  [DIV_STEPS+1];
  logic        za_r   [DIV_STEPS+1];

  fr_t out_r;

  always_comb begin
    nh_c = -53'(in_sq.h);
    sx_c = $signed({2'b0, in_sq.s});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r  <= in_sq.meta.in1 ? (nh_c + sx_c) : (nh_c - sx_c);
      meta1_r <= in_sq.meta;
      a1_r    <= in_sq.a;
      // clamp to [0, a]
      rem_r[0]  <= (num1_r[52] || num1_r >= $signed({3'b0, a1_r})) ? '0 : num1_r[49:0];
      one_r[0]  <= !num1_r[52] && (num1_r >= $signed({3'b0, a1_r}));
      za_r[0]   <= (a1_r == '0);
      q_r[0]    <= '0;
      a_r[0]    <= a1_r;
      meta_r[0] <= meta1_r;
      // fraction select
      out_r.meta <= meta_r[DIV_STEPS];
      if (za_r[DIV_STEPS]) begin
        out_r.mu <= '0;
      end else if (one_r[DIV_STEPS]) begin
        out_r.mu <= ONE_Q16;
      end else begin
        out_r.mu <= {1'b0, q_r[DIV_STEPS]};
      end
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [50:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_r[k-1], 1'b0};
      ge    = trial >= {1'b0, a_r[k-1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 50'(trial - {1'b0, a_r[k-1]}) : trial[49:0];
        q_r[k]    <= {q_r[k-1][14:0], ge};
        a_r[k]    <= a_r[k-1];
        meta_r[k] <= meta_r[k-1];
        one_r[k]  <= one_r[k-1];
        za_r[k]   <= za_r[k-1];
      end
    end
  end

  assign out_vld = vld_r[NST-1];
  assign out_fr  = out_r;

endmodule

// ===== hdl/scedg_dens.sv =====
// ----------------------------------------------------------------------------
// scedg_dens
// new density from the crossing fraction, pipelined divide and saturation
// ----------------------------------------------------------------------------
module scedg_dens (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  scedg_pkg::fr_t       in_fr,
  input  logic signed [15:0]   iso,
  output logic                 out_vld,
  output scedg_pkg::out_beat_t out_beat
);
  import scedg_pkg::*;

  localparam int NST = DIV_STEPS + 5;

  logic [NST-1:0] vld_r;

  // stage 1
  logic [16:0]        f_c;
  logic [16:0]        f1_r;
  logic signed [15:0] oth1_r;
  meta_t              meta1_r;
  // stage 2
  logic signed [33:0] prod2_r;
  logic [16:0]        dm2_r;
  logic               den02_r;
  meta_t              meta2_r;
  // stage 3
  logic signed [34:0] num3_r;
  logic [16:0]        dm3_r;
  logic               den03_r;
  meta_t              meta3_r;
  logic signed [34:0] nabs_c;

  // divide chain
  logic [17:0] rem_r  [DIV_STEPS+1];
  logic [15:0] low_r  [DIV_STEPS+1];
  logic [15:0] q_r    [DIV_STEPS+1];
  logic [16:0] dm_r   [DIV_STEPS+1];
  logic        ovf_r  [DIV_STEPS+1];
  logic        qneg_r [DIV_STEPS+1];
  logic        den0_r [DIV_STEPS+1];
  meta_t       meta_r [DIV_STEPS+1];

  logic signed [15:0] v_c;
  meta_t              mf;
  out_beat_t          res_c;
  out_beat_t          out_r;

  always_comb begin
    if (in_fr.meta.axis == AXIS_NONE) begin
      f_c = '0;
    end else if (!in_fr.meta.dug1) begin
      f_c = in_fr.mu;
    end else begin
      f_c = ONE_Q16 - in_fr.mu;
    end
  end

  assign nabs_c = num3_r[34] ? -num3_r : num3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r    <= f_c;
      oth1_r  <= in_fr.meta.dug1 ? in_fr.meta.d1 : in_fr.meta.d2;
      meta1_r <= in_fr.meta;

      prod2_r <= oth1_r * $signed({1'b0, f1_r});
      dm2_r   <= ONE_Q16 - f1_r;
      den02_r <= (f1_r == ONE_Q16);
      meta2_r <= meta1_r;

      num3_r  <= 35'(prod2_r) - (35'(iso) <<< 16);
      dm3_r   <= dm2_r;
      den03_r <= den02_r;
      meta3_r <= meta2_r;

      // divisor is negative, so the quotient is negative for a positive numerator
      rem_r[0]  <= {1'b0, nabs_c[32:16]};
      low_r[0]  <= nabs_c[15:0];
      q_r[0]    <= '0;
      dm_r[0]   <= dm3_r;
      ovf_r[0]  <= nabs_c[33:0] >= {1'b0, dm3_r, 16'b0};
      qneg_r[0] <= !num3_r[34] && (num3_r != '0);
      den0_r[0] <= den03_r;
      meta_r[0] <= meta3_r;

      out_r <= res_c;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [17:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_r[k-1][16:0], low_r[k-1][15]};
      ge    = trial >= {1'b0, dm_r[k-1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (trial - {1'b0, dm_r[k-1]}) : trial;
        low_r[k]  <= {low_r[k-1][14:0], 1'b0};
        q_r[k]    <= {q_r[k-1][14:0], ge};
        dm_r[k]   <= dm_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        qneg_r[k] <= qneg_r[k-1];
        den0_r[k] <= den0_r[k-1];
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  always_comb begin
    mf = meta_r[DIV_STEPS];
    if (qneg_r[DIV_STEPS]) begin
      if (ovf_r[DIV_STEPS] || q_r[DIV_STEPS] > 16'd32768) begin
        v_c = -16'sd32768;
      end else begin
        v_c = $signed(16'(-q_r[DIV_STEPS]));
      end
    end else begin
      if (ovf_r[DIV_STEPS] || q_r[DIV_STEPS] > 16'd32767) begin
        v_c = 16'sd32767;
      end else begin
        v_c = $signed(q_r[DIV_STEPS]);
      end
    end
    res_c.new_first_density  = mf.d1;
    res_c.new_second_density = mf.d2;
    res_c.new_first_dug      = mf.dug1;
    res_c.new_second_dug     = mf.dug2;
    res_c.edited             = mf.act;
    if (mf.act) begin
      if (!mf.dug1) begin
        res_c.new_first_dug = 1'b1;
        if (!mf.zdiv && !den0_r[DIV_STEPS]) begin
          res_c.new_first_density = v_c;
        end
      end else begin
        res_c.new_second_dug = 1'b1;
        if (!mf.zdiv && !den0_r[DIV_STEPS]) begin
          res_c.new_second_density = v_c;
        end
      end
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_beat = out_r;

endmodule

// ===== hdl/sphere_carve_edge_density.sv =====
// ----------------------------------------------------------------------------
// sphere_carve_edge_density
// density edit for one grid edge cut by a dig sphere
// ----------------------------------------------------------------------------
// in_valid/in_ready/in_data carry one edge per beat: both end positions,
// densities, dug flags and the edge axis. out_valid/out_ready/out_data
// return exactly one beat per edge, in order, with the edited densities and
// dug flags and the edited flag.
// sphere center, radius and iso level are written over the apb port
// (byte address 4 * register index); the user must write them only while
// no edge is in flight, and the block itself does not enforce this.
// the pipe has 8 geometry stages, 51 square root stages, 19 fraction
// stages and 21 density stages, the last of which is the output register.
// throughput is one edge per cycle unless stalled; every stage advances
// together. when the receiver holds out_ready low with a beat waiting,
// the whole pipe holds and in_ready drops, so nothing is lost or repeated.
// rst_n clears all stage valid bits and the apb registers to zero.
// ----------------------------------------------------------------------------
module sphere_carve_edge_density (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scedg_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scedg_pkg::out_beat_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import scedg_pkg::*;

  logic signed [23:0] cx_r;
  logic signed [23:0] cy_r;
  logic signed [23:0] cz_r;
  logic [19:0]        radius_r;
  logic signed [15:0] iso_r;
  logic               wr_en;
  logic               en;

  logic geo_vld;
  geo_t geo;
  logic sq_vld;
  sq_t  sq;
  logic fr_vld;
  fr_t  fr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
      radius_r <= '0;
      iso_r    <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_CENTER_X: cx_r     <= pwdata[23:0];
        REG_CENTER_Y: cy_r     <= pwdata[23:0];
        REG_CENTER_Z: cz_r     <= pwdata[23:0];
        REG_RADIUS:   radius_r <= pwdata[19:0];
        REG_ISO:      iso_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_CENTER_X: prdata = {8'b0, cx_r};
      REG_CENTER_Y: prdata = {8'b0, cy_r};
      REG_CENTER_Z: prdata = {8'b0, cz_r};
      REG_RADIUS:   prdata = {12'b0, radius_r};
      REG_ISO:      prdata = {16'b0, iso_r};
      default:      prdata = '0;
    endcase
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  scedg_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_beat (in_data),
    .cx      (cx_r),
    .cy      (cy_r),
    .cz      (cz_r),
    .radius  (radius_r),
    .out_vld (geo_vld),
    .out_geo (geo)
  );

  scedg_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (geo_vld),
    .in_geo  (geo),
    .out_vld (sq_vld),
    .out_sq  (sq)
  );

  scedg_frac u_frac (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .in_sq   (sq),
    .out_vld (fr_vld),
    .out_fr  (fr)
  );

  scedg_dens u_dens (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_fr    (fr),
    .iso      (iso_r),
    .out_vld  (out_valid),
    .out_beat (out_data)
  );

endmodule
